// ===== rtl/slvs_pkg.sv =====
// Package for the scoped label value stack: entry layout, request, status and
// permission codes, controller states and the command and status bundles.
// No dependencies.
package slvs_pkg;

  localparam int LBL_W  = 16;
  localparam int VAL_W  = 32;
  localparam int REQ_W  = 4;
  localparam int ST_W   = 3;
  localparam int PERM_W = 3;

  localparam logic [LBL_W-1:0] LBL_EMPTY = 16'h0000;
  localparam logic [LBL_W-1:0] LBL_SEP   = 16'hFFFF;

  localparam logic [REQ_W-1:0] REQ_OPEN     = 4'd0;
  localparam logic [REQ_W-1:0] REQ_CLOSE    = 4'd1;
  localparam logic [REQ_W-1:0] REQ_SET_FREE = 4'd2;
  localparam logic [REQ_W-1:0] REQ_SET_LOCK = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SET_ONCE = 4'd4;
  localparam logic [REQ_W-1:0] REQ_SET_MUL  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_REWRITE  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_MUL      = 4'd7;
  localparam logic [REQ_W-1:0] REQ_GET      = 4'd8;
  localparam logic [REQ_W-1:0] REQ_CHECK    = 4'd9;

  localparam logic [PERM_W-1:0] PERM_FREE  = 3'd0;
  localparam logic [PERM_W-1:0] PERM_ONCE  = 3'd1;
  localparam logic [PERM_W-1:0] PERM_SPENT = 3'd2;
  localparam logic [PERM_W-1:0] PERM_MUL   = 3'd3;
  localparam logic [PERM_W-1:0] PERM_LOCK  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd2;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [ST_W-1:0] ST_DUP      = 3'd4;
  localparam logic [ST_W-1:0] ST_DENIED   = 3'd5;
  localparam logic [ST_W-1:0] ST_NOTEMPTY = 3'd6;

  typedef struct packed {
    logic [LBL_W-1:0]        label;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic [PERM_W-1:0]       perm;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_F_ADDR, S_F_LOOK, S_M_RND, S_M_WR,
    S_CL_UP_ADDR, S_CL_UP_LOOK, S_CL_SEP, S_CL_DN, S_CL_DN_ADDR, S_CL_DN_LOOK,
    S_CLR, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_FB, PTR_FBM1, PTR_INC, PTR_DEC, PTR_ZERO
  } ptr_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_CLEAR, WR_SEP, WR_SET, WR_VALUE, WR_MUL
  } wr_op_t;

  typedef enum logic [1:0] {
    FB_HOLD, FB_PTR1, FB_ZERO
  } fb_op_t;

  typedef struct packed {
    logic            ld_req;
    ptr_op_t         ptr_op;
    wr_op_t          wr_op;
    fb_op_t          fb_op;
    logic            mul_ld;
    logic            sat_ld;
    logic            res_ld;
    logic [ST_W-1:0] res_st;
    logic            res_acc;
    logic            res_rd;
    logic            out_ld;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0]  in_req;
    logic              in_bad_label;
    logic [REQ_W-1:0]  cur_req;
    logic              ptr_end;
    logic              ptr_zero;
    logic              ptr_last;
    logic              ptr_room;
    logic              fb_zero;
    logic              ent_empty;
    logic              ent_sep;
    logic              ent_match;
    logic [PERM_W-1:0] ent_perm;
    logic              out_free;
  } stat_t;

endpackage

// ===== rtl/slvs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module slvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/slvs_ctrl.sv =====
// Controller state machine of the scoped label value stack.
// Depends on slvs_pkg; drives the datapath through cmd_t and reads stat_t.
module slvs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  slvs_pkg::stat_t stat,
  output slvs_pkg::cmd_t  cmd
);
  import slvs_pkg::*;

  state_t state, state_next;
  logic   found_end;
  logic   hit;
  logic   in_needs_label;

  assign found_end      = stat.ptr_end || stat.ent_empty;
  assign hit            = !found_end && stat.ent_match && (stat.cur_req != REQ_OPEN);
  assign in_needs_label = (stat.in_req >= REQ_SET_FREE) && (stat.in_req <= REQ_GET);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (stat.ptr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_needs_label && stat.in_bad_label) begin
            state_next = S_DONE;
          end else if (stat.in_req == REQ_OPEN || in_needs_label) begin
            state_next = S_F_ADDR;
          end else if (stat.in_req == REQ_CLOSE) begin
            state_next = stat.fb_zero ? S_DONE : S_CL_UP_ADDR;
          end else if (stat.in_req == REQ_CHECK) begin
            state_next = stat.fb_zero ? S_DONE : S_CLR;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_F_ADDR: state_next = S_F_LOOK;
      S_F_LOOK: begin
        if (hit && stat.cur_req == REQ_MUL && stat.ent_perm == PERM_MUL) begin
          state_next = S_M_RND;
        end else if (hit || found_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_F_ADDR;
        end
      end
      S_M_RND:      state_next = S_M_WR;
      S_M_WR:       state_next = S_DONE;
      S_CL_UP_ADDR: state_next = S_CL_UP_LOOK;
      S_CL_UP_LOOK: state_next = found_end ? S_CL_SEP : S_CL_UP_ADDR;
      S_CL_SEP:     state_next = S_CL_DN;
      S_CL_DN:      state_next = stat.ptr_zero ? S_DONE : S_CL_DN_ADDR;
      S_CL_DN_ADDR: state_next = S_CL_DN_LOOK;
      S_CL_DN_LOOK: state_next = stat.ent_sep ? S_DONE : S_CL_DN;
      S_CLR: begin
        if (stat.ptr_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.wr_op  = WR_NONE;
    cmd.fb_op  = FB_HOLD;
    cmd.res_st = ST_OK;
    in_stall   = 1'b1;
    unique case (state)
      S_INIT: begin
        cmd.wr_op  = WR_CLEAR;
        cmd.ptr_op = PTR_INC;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          cmd.ptr_op = PTR_FB;
          if (in_needs_label && stat.in_bad_label) begin
            cmd.res_ld = 1'b1;
            cmd.res_st = ST_DENIED;
          end else if (stat.in_req == REQ_OPEN || in_needs_label) begin
            cmd.res_ld = 1'b0;
          end else if (stat.in_req == REQ_CLOSE) begin
            if (stat.fb_zero) begin
              cmd.res_ld = 1'b1;
              cmd.res_st = ST_UNDERFLOW;
            end
          end else if (stat.in_req == REQ_CHECK) begin
            if (stat.fb_zero) begin
              cmd.res_ld = 1'b1;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              cmd.fb_op  = FB_ZERO;
            end
          end else begin
            cmd.res_ld = 1'b1;
            cmd.res_st = ST_DENIED;
          end
        end
      end
      S_F_LOOK: begin
        if (stat.cur_req == REQ_OPEN) begin
          if (found_end) begin
            cmd.res_ld = 1'b1;
            if (stat.ptr_room) begin
              cmd.wr_op   = WR_SEP;
              cmd.fb_op   = FB_PTR1;
              cmd.res_acc = 1'b1;
            end else begin
              cmd.res_st = ST_OVERFLOW;
            end
          end else begin
            cmd.ptr_op = PTR_INC;
          end
        end else if (hit) begin
          case (stat.cur_req)
            REQ_REWRITE: begin
              cmd.res_ld = 1'b1;
              if (stat.ent_perm == PERM_FREE || stat.ent_perm == PERM_ONCE) begin
                cmd.wr_op   = WR_VALUE;
                cmd.res_acc = 1'b1;
              end else begin
                cmd.res_st = ST_DENIED;
              end
            end
            REQ_MUL: begin
              if (stat.ent_perm == PERM_MUL) begin
                cmd.mul_ld = 1'b1;
              end else begin
                cmd.res_ld = 1'b1;
                cmd.res_st = ST_DENIED;
              end
            end
            REQ_GET: begin
              cmd.res_ld  = 1'b1;
              cmd.res_acc = 1'b1;
              cmd.res_rd  = 1'b1;
            end
            default: begin
              cmd.wr_op   = WR_SET;
              cmd.res_ld  = 1'b1;
              cmd.res_acc = 1'b1;
              cmd.res_st  = ST_DUP;
            end
          endcase
        end else if (found_end) begin
          cmd.res_ld = 1'b1;
          if (stat.cur_req >= REQ_REWRITE) begin
            cmd.res_st = ST_NOTFOUND;
          end else if (stat.ptr_end) begin
            cmd.res_st = ST_OVERFLOW;
          end else begin
            cmd.wr_op   = WR_SET;
            cmd.res_acc = 1'b1;
          end
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_M_RND: cmd.sat_ld = 1'b1;
      S_M_WR: begin
        cmd.wr_op   = WR_MUL;
        cmd.res_ld  = 1'b1;
        cmd.res_acc = 1'b1;
      end
      S_CL_UP_LOOK: begin
        if (found_end) begin
          cmd.ptr_op = PTR_FBM1;
        end else begin
          cmd.wr_op  = WR_CLEAR;
          cmd.ptr_op = PTR_INC;
        end
      end
      S_CL_SEP: cmd.wr_op = WR_CLEAR;
      S_CL_DN: begin
        if (stat.ptr_zero) begin
          cmd.fb_op   = FB_ZERO;
          cmd.res_ld  = 1'b1;
          cmd.res_acc = 1'b1;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_CL_DN_LOOK: begin
        if (stat.ent_sep) begin
          cmd.fb_op   = FB_PTR1;
          cmd.res_ld  = 1'b1;
          cmd.res_acc = 1'b1;
        end
      end
      S_CLR: begin
        cmd.wr_op  = WR_CLEAR;
        cmd.ptr_op = PTR_INC;
        if (stat.ptr_last) begin
          cmd.res_ld  = 1'b1;
          cmd.res_acc = 1'b1;
          cmd.res_st  = ST_NOTEMPTY;
        end
      end
      S_DONE: cmd.out_ld = stat.out_free;
      default: cmd.ld_req = 1'b0;
    endcase
  end

endmodule

// ===== rtl/slvs_dp.sv =====
// Datapath of the scoped label value stack: request registers, scan pointer,
// frame base, entry RAM, fixed-point multiplier and result registers.
// Depends on slvs_pkg and slvs_ram.
module slvs_dp #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [slvs_pkg::REQ_W-1:0]          req_type,
  input  logic [slvs_pkg::LBL_W-1:0]          label_code,
  input  logic signed [slvs_pkg::VAL_W-1:0]   data_word,
  input  logic signed [slvs_pkg::VAL_W-1:0]   clamp_low,
  input  logic signed [slvs_pkg::VAL_W-1:0]   clamp_high,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [slvs_pkg::VAL_W-1:0]   read_value,
  output logic                                accepted,
  output logic [slvs_pkg::ST_W-1:0]           status_code,
  input  slvs_pkg::cmd_t                      cmd,
  output slvs_pkg::stat_t                     stat
);
  import slvs_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] PTR_END  = PW'(STACK_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(STACK_DEPTH - 1);
  localparam logic signed [63:0] RND     = 64'sd2048;
  localparam logic signed [63:0] VAL_MAX = 64'sd2147483647;
  localparam logic signed [63:0] VAL_MIN = -64'sd2147483648;

  logic [REQ_W-1:0]        req_r;
  logic [LBL_W-1:0]        label_r;
  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] lo_r;
  logic signed [VAL_W-1:0] hi_r;

  logic [PW-1:0] ptr, ptr_next;
  logic [AW-1:0] fb, fb_next;

  entry_t rd_ent;
  entry_t wr_ent;
  logic [ENTRY_W-1:0] rdata;
  logic               we;

  logic signed [63:0]      prod;
  logic signed [63:0]      rnd;
  logic signed [VAL_W-1:0] sat, sat_next;
  logic signed [VAL_W-1:0] clamped;

  logic                    res_acc;
  logic [ST_W-1:0]         res_st;
  logic signed [VAL_W-1:0] res_rd;

  assign rd_ent = entry_t'(rdata);

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      req_r   <= req_type;
      label_r <= label_code;
      data_r  <= data_word;
      lo_r    <= clamp_low;
      hi_r    <= clamp_high;
    end
  end

  always_comb begin
    ptr_next = ptr;
    case (cmd.ptr_op)
      PTR_FB:   ptr_next = PW'(fb);
      PTR_FBM1: ptr_next = PW'(fb) - PW'(1);
      PTR_INC:  ptr_next = ptr + PW'(1);
      PTR_DEC:  ptr_next = ptr - PW'(1);
      PTR_ZERO: ptr_next = '0;
      default:  ptr_next = ptr;
    endcase
  end

  always_comb begin
    fb_next = fb;
    case (cmd.fb_op)
      FB_PTR1: fb_next = ptr[AW-1:0] + AW'(1);
      FB_ZERO: fb_next = '0;
      default: fb_next = fb;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      fb  <= '0;
    end else begin
      ptr <= ptr_next;
      fb  <= fb_next;
    end
  end

  // Entry write data for each kind of update.
  always_comb begin
    wr_ent = rd_ent;
    case (cmd.wr_op)
      WR_CLEAR: wr_ent = '0;
      WR_SEP: begin
        wr_ent       = '0;
        wr_ent.label = LBL_SEP;
      end
      WR_SET: begin
        wr_ent.label = label_r;
        wr_ent.value = data_r;
        wr_ent.low   = (req_r == REQ_SET_MUL) ? lo_r : '0;
        wr_ent.high  = (req_r == REQ_SET_MUL) ? hi_r : '0;
        case (req_r)
          REQ_SET_FREE: wr_ent.perm = PERM_FREE;
          REQ_SET_LOCK: wr_ent.perm = PERM_LOCK;
          REQ_SET_ONCE: wr_ent.perm = PERM_ONCE;
          default:      wr_ent.perm = PERM_MUL;
        endcase
      end
      WR_VALUE: begin
        wr_ent.value = data_r;
        if (rd_ent.perm == PERM_ONCE) wr_ent.perm = PERM_SPENT;
      end
      WR_MUL:  wr_ent.value = clamped;
      default: wr_ent = rd_ent;
    endcase
  end

  assign we = (cmd.wr_op != WR_NONE);

  slvs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ptr[AW-1:0]),
    .wdata (wr_ent),
    .raddr (ptr[AW-1:0]),
    .rdata (rdata)
  );

  // Product of 20.12 values, rounded by adding half and shifting with floor, then
  // saturated; the clamp runs in the following cycle.
  assign rnd = (prod + RND) >>> 12;

  always_comb begin
    if (rnd > VAL_MAX) begin
      sat_next = VAL_W'(VAL_MAX);
    end else if (rnd < VAL_MIN) begin
      sat_next = VAL_W'(VAL_MIN);
    end else begin
      sat_next = VAL_W'(rnd);
    end
  end

  always_comb begin
    clamped = sat;
    if (rd_ent.low != '0 || rd_ent.high != '0) begin
      if (rd_ent.low > clamped)  clamped = rd_ent.low;
      if (rd_ent.high < clamped) clamped = rd_ent.high;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) prod <= 64'(rd_ent.value) * 64'(data_r);
    if (cmd.sat_ld) sat  <= sat_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_st  <= cmd.res_st;
      res_acc <= cmd.res_acc;
      res_rd  <= cmd.res_rd ? rd_ent.value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      read_value  <= res_rd;
      accepted    <= res_acc;
      status_code <= res_st;
    end
  end

  always_comb begin
    stat.in_req       = req_type;
    stat.in_bad_label = (label_code == LBL_EMPTY) || (label_code == LBL_SEP);
    stat.cur_req      = req_r;
    stat.ptr_end      = (ptr == PTR_END);
    stat.ptr_zero     = (ptr == '0);
    stat.ptr_last     = (ptr == PTR_LAST);
    stat.ptr_room     = (ptr < PTR_LAST);
    stat.fb_zero      = (fb == '0);
    stat.ent_empty    = (rd_ent.label == LBL_EMPTY);
    stat.ent_sep      = (rd_ent.label == LBL_SEP);
    stat.ent_match    = (rd_ent.label == label_r);
    stat.ent_perm     = rd_ent.perm;
    stat.out_free     = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/scoped_label_value_stack.sv =====
// Top level of the scoped label value stack; depends on slvs_pkg, slvs_ctrl, slvs_dp.
// A lookup reads entries one at a time from the frame base up; a multiply adds a rounding
// step and a write-back step; a close clears each entry read in its frame, clears the
// separator and walks back to the separator below; other codes answer straight from idle.
// One request at a time: the next is taken in the cycle after the result is loaded.
// Reset, and a check on a non-empty stack, clear the whole label RAM.
module scoped_label_value_stack #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [slvs_pkg::REQ_W-1:0]         req_type,
  input  logic [slvs_pkg::LBL_W-1:0]         label_code,
  input  logic signed [slvs_pkg::VAL_W-1:0]  data_word,
  input  logic signed [slvs_pkg::VAL_W-1:0]  clamp_low,
  input  logic signed [slvs_pkg::VAL_W-1:0]  clamp_high,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [slvs_pkg::VAL_W-1:0]  read_value,
  output logic                               accepted,
  output logic [slvs_pkg::ST_W-1:0]          status_code
);
  import slvs_pkg::*;

  // The controller sequences every lookup, close and check as a walk of the scan pointer over
  // the entry RAM. It issues one command bundle per cycle and decides from the
  // status bundle the datapath returns.
  cmd_t  cmd;
  stat_t stat;

  slvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the frame base, the scan pointer, the entries and the
  // output register, so a finished result waits there while the next transfer
  // on the input side is taken.
  slvs_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .label_code  (label_code),
    .data_word   (data_word),
    .clamp_low   (clamp_low),
    .clamp_high  (clamp_high),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .read_value  (read_value),
    .accepted    (accepted),
    .status_code (status_code),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

// ===== rtl/slvs_checker.sv =====
// Port-level checker for the scoped label value stack, bound to the top level.
// Depends on slvs_pkg.
module slvs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [slvs_pkg::VAL_W-1:0]  read_value,
  input logic                               accepted,
  input logic [slvs_pkg::ST_W-1:0]          status_code
);
  import slvs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status_code))
    else $error("stalled result changed");

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_value != '0 |-> accepted && status_code == ST_OK)
    else $error("read value without a successful get");

  a_acc_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |->
      status_code == ST_OK || status_code == ST_DUP || status_code == ST_NOTEMPTY)
    else $error("accepted with an error status");

endmodule

bind scoped_label_value_stack slvs_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_value  (read_value),
  .accepted    (accepted),
  .status_code (status_code)
);
